// ----- src/rgbf_pkg.sv -----
// rgbf_pkg: shared types, constants and channel helpers for the rgb555 color filter
package rgbf_pkg;

   localparam int CH_W    = 5;
   localparam int WORD_W  = 16;
   localparam int MODE_W  = 5;

   // weighted sums stay below 2^13, quotients by 100 below 2^6
   localparam int SUM_W   = 13;
   localparam int PROD_W  = 25;
   localparam int QUO_W   = 6;

   // x / 100 == (x * 5243) >> 19 for every x below 43690
   localparam logic [PROD_W-1:0] RECIP_100   = PROD_W'(5243);
   localparam int                RECIP_SHIFT = 19;
   // s / 3 == (s * 43) >> 7 for every s below 128
   localparam logic [11:0]       RECIP_3     = 12'd43;

   localparam logic [CH_W-1:0]   CH_MAX      = 5'd31;

   typedef enum logic [MODE_W-1:0] {
      MODE_NONE     = 5'd0,
      MODE_VIBRANT  = 5'd1,
      MODE_CONTRAST = 5'd2,
      MODE_POSTER   = 5'd3,
      MODE_WARM     = 5'd4,
      MODE_COLD     = 5'd5,
      MODE_ETHEREAL = 5'd6,
      MODE_WATER    = 5'd7,
      MODE_GOLDEN   = 5'd8,
      MODE_DREAMY   = 5'd9,
      MODE_RETRO    = 5'd10,
      MODE_ALIEN    = 5'd11,
      MODE_SPACE    = 5'd12,
      MODE_SEPIA    = 5'd13,
      MODE_GRAY     = 5'd14,
      MODE_MONO     = 5'd15,
      MODE_INVERT   = 5'd16,
      MODE_SWAP     = 5'd17
   } filter_mode_type;

   // add with clamp at 31
   function automatic logic [CH_W-1:0] sat_add(input logic [CH_W-1:0] v,
                                                input logic [CH_W-1:0] k);
      logic [CH_W:0] s;
      s = {1'b0, v} + {1'b0, k};
      return s[CH_W] ? CH_MAX : s[CH_W-1:0];
   endfunction

   // subtract with clamp at 0
   function automatic logic [CH_W-1:0] sat_sub(input logic [CH_W-1:0] v,
                                                input logic [CH_W-1:0] k);
      return (v > k) ? v - k : '0;
   endfunction

   // clamp a quotient to the channel range
   function automatic logic [CH_W-1:0] clamp_ch(input logic [QUO_W-1:0] q);
      return (q > QUO_W'(CH_MAX)) ? CH_MAX : q[CH_W-1:0];
   endfunction

   function automatic logic [WORD_W-1:0] pack(input logic [CH_W-1:0] r,
                                              input logic [CH_W-1:0] g,
                                              input logic [CH_W-1:0] b);
      return {1'b0, b, g, r};
   endfunction

endpackage

// ----- src/rgb555_color_filter.sv -----
// rgb555_color_filter: four-stage pipelined five-five-five color word filter
//
// Usage: a color word enters on the req_ channel (valid/ready) and the
// filtered word leaves on the rsp_ channel (valid/ready), one result beat
// for every request beat, in order. The filter is picked by the mode
// register, written through csr_write_enable / csr_write_data; change it
// only while no beat is in flight.
// Path: input register, then weighted sums, reciprocal divides, filter
// select, each stage registered; rsp_valid is the last stage's valid bit.
// Throughput: one beat per cycle while rsp_ready is high; every stage
// holds one beat, moves it on once the next stage is free; bubbles close up.
// Stall: when rsp_ready is low the output beat holds, the stages behind
// it fill up, and req_ready drops only once all four stages are full.
// Reset: all stage valid bits clear and the mode returns to pass-through.
module rgb555_color_filter
   import rgbf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [WORD_W-1:0]   req_color_in,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [WORD_W-1:0]   rsp_color_out,
   input  logic                csr_write_enable,
   input  logic [MODE_W-1:0]   csr_write_data
);

   // mode register
   filter_mode_type mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NONE;
      end else if (csr_write_enable) begin
         mode_ff <= filter_mode_type'(csr_write_data);
      end
   end

   // stage valid bits and per-stage ready
   logic valid_a_ff, valid_b_ff, valid_c_ff, valid_d_ff;
   logic ready_a, ready_b, ready_c, ready_d;

   assign ready_d   = !valid_d_ff || rsp_ready;
   assign ready_c   = !valid_c_ff || ready_d;
   assign ready_b   = !valid_b_ff || ready_c;
   assign ready_a   = !valid_a_ff || ready_b;
   assign req_ready = ready_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
         valid_d_ff <= 1'b0;
      end else begin
         if (ready_a) valid_a_ff <= req_valid;
         if (ready_b) valid_b_ff <= valid_a_ff;
         if (ready_c) valid_c_ff <= valid_b_ff;
         if (ready_d) valid_d_ff <= valid_c_ff;
      end
   end

   // stage a: capture the beat
   logic [WORD_W-1:0] color_a_ff;
   filter_mode_type   mode_a_ff;

   always_ff @(posedge clock) begin
      if (ready_a && req_valid) begin
         color_a_ff <= req_color_in;
         mode_a_ff  <= mode_ff;
      end
   end

   // stage b: weighted channel sums
   logic [CH_W-1:0]  r_a, g_a, b_a;
   logic [SUM_W-1:0] sep_r_in, sep_g_in, sep_b_in, luma_in;
   logic [6:0]       sum3_in;

   assign r_a = color_a_ff[4:0];
   assign g_a = color_a_ff[9:5];
   assign b_a = color_a_ff[14:10];

   always_comb begin
      sep_r_in = SUM_W'(r_a) * SUM_W'(39) + SUM_W'(g_a) * SUM_W'(77)
               + SUM_W'(b_a) * SUM_W'(19);
      sep_g_in = SUM_W'(r_a) * SUM_W'(35) + SUM_W'(g_a) * SUM_W'(69)
               + SUM_W'(b_a) * SUM_W'(17);
      sep_b_in = SUM_W'(r_a) * SUM_W'(27) + SUM_W'(g_a) * SUM_W'(53)
               + SUM_W'(b_a) * SUM_W'(13);
      luma_in  = SUM_W'(r_a) * SUM_W'(30) + SUM_W'(g_a) * SUM_W'(59)
               + SUM_W'(b_a) * SUM_W'(11);
      sum3_in  = 7'(r_a) + 7'(g_a) + 7'(b_a);
   end

   logic [SUM_W-1:0]  sep_r_ff, sep_g_ff, sep_b_ff, luma_ff;
   logic [6:0]        sum3_ff;
   logic [WORD_W-1:0] color_b_ff;
   filter_mode_type   mode_b_ff;

   always_ff @(posedge clock) begin
      if (ready_b && valid_a_ff) begin
         sep_r_ff   <= sep_r_in;
         sep_g_ff   <= sep_g_in;
         sep_b_ff   <= sep_b_in;
         luma_ff    <= luma_in;
         sum3_ff    <= sum3_in;
         color_b_ff <= color_a_ff;
         mode_b_ff  <= mode_a_ff;
      end
   end

   // stage c: divide by 100 and by 3 through reciprocal multiplies
   logic [PROD_W-1:0] sep_r_prod, sep_g_prod, sep_b_prod, luma_prod;
   logic [11:0]       avg_prod;
   logic [CH_W-1:0]   sep_r_q_in, sep_g_q_in, sep_b_q_in, luma_q_in, avg_q_in;

   always_comb begin
      sep_r_prod = PROD_W'(sep_r_ff) * RECIP_100;
      sep_g_prod = PROD_W'(sep_g_ff) * RECIP_100;
      sep_b_prod = PROD_W'(sep_b_ff) * RECIP_100;
      luma_prod  = PROD_W'(luma_ff) * RECIP_100;
      avg_prod   = 12'(sum3_ff) * RECIP_3;
      sep_r_q_in = clamp_ch(sep_r_prod[RECIP_SHIFT +: QUO_W]);
      sep_g_q_in = clamp_ch(sep_g_prod[RECIP_SHIFT +: QUO_W]);
      sep_b_q_in = clamp_ch(sep_b_prod[RECIP_SHIFT +: QUO_W]);
      // luma never exceeds 31
      luma_q_in  = luma_prod[RECIP_SHIFT +: CH_W];
      avg_q_in   = avg_prod[11:7];
   end

   logic [CH_W-1:0]   sep_r_q_ff, sep_g_q_ff, sep_b_q_ff, luma_q_ff, avg_q_ff;
   logic [WORD_W-1:0] color_c_ff;
   filter_mode_type   mode_c_ff;

   always_ff @(posedge clock) begin
      if (ready_c && valid_b_ff) begin
         sep_r_q_ff <= sep_r_q_in;
         sep_g_q_ff <= sep_g_q_in;
         sep_b_q_ff <= sep_b_q_in;
         luma_q_ff  <= luma_q_in;
         avg_q_ff   <= avg_q_in;
         color_c_ff <= color_b_ff;
         mode_c_ff  <= mode_b_ff;
      end
   end

   // stage d: per-channel filters and mode select
   logic [CH_W-1:0]   r_c, g_c, b_c;
   logic [CH_W:0]     r_dream, g_dream, b_dream;
   logic [WORD_W-1:0] color_out_in;

   assign r_c = color_c_ff[4:0];
   assign g_c = color_c_ff[9:5];
   assign b_c = color_c_ff[14:10];

   assign r_dream = {1'b0, r_c} + {1'b0, CH_MAX};
   assign g_dream = {1'b0, g_c} + {1'b0, CH_MAX};
   assign b_dream = {1'b0, b_c} + {1'b0, CH_MAX};

   always_comb begin
      unique case (mode_c_ff)
         MODE_VIBRANT: begin
            // first channel that holds the maximum gets the boost
            if (r_c >= g_c && r_c >= b_c) begin
               color_out_in = pack(sat_add(r_c, 5'd2), sat_sub(g_c, 5'd2),
                                   sat_sub(b_c, 5'd2));
            end else if (g_c >= b_c) begin
               color_out_in = pack(sat_sub(r_c, 5'd2), sat_add(g_c, 5'd2),
                                   sat_sub(b_c, 5'd2));
            end else begin
               color_out_in = pack(sat_sub(r_c, 5'd2), sat_sub(g_c, 5'd2),
                                   sat_add(b_c, 5'd2));
            end
         end
         MODE_CONTRAST:
            color_out_in = pack(
               (r_c > 5'd15) ? sat_add(r_c, 5'd8) : sat_sub(r_c, 5'd8),
               (g_c > 5'd15) ? sat_add(g_c, 5'd8) : sat_sub(g_c, 5'd8),
               (b_c > 5'd15) ? sat_add(b_c, 5'd8) : sat_sub(b_c, 5'd8));
         MODE_POSTER:
            color_out_in = pack(r_c & 5'd24, g_c & 5'd24, b_c & 5'd24);
         MODE_WARM:
            color_out_in = pack(sat_add(r_c, 5'd5), g_c, b_c);
         MODE_COLD:
            color_out_in = pack(r_c, g_c, sat_add(b_c, 5'd5));
         MODE_ETHEREAL:
            color_out_in = pack(sat_add(sat_add(r_c, 5'd3), 5'd4), sat_sub(g_c, 5'd2),
                                sat_add(sat_add(b_c, 5'd5), 5'd4));
         MODE_WATER:
            color_out_in = pack(r_c >> 1, sat_add(g_c, 5'd8), sat_add(b_c, 5'd8));
         MODE_GOLDEN:
            color_out_in = pack(sat_add(r_c, 5'd6), sat_add(g_c, 5'd4), b_c >> 1);
         MODE_DREAMY:
            color_out_in = pack(r_dream[CH_W:1], g_dream[CH_W:1], b_dream[CH_W:1]);
         MODE_RETRO:
            color_out_in = pack((r_c > 5'd16) ? CH_MAX : '0,
                                (g_c > 5'd16) ? CH_MAX : '0,
                                (b_c > 5'd16) ? CH_MAX : '0);
         MODE_ALIEN:
            color_out_in = pack(b_c, r_c, g_c);
         MODE_SPACE:
            color_out_in = pack(avg_q_ff, b_c, avg_q_ff);
         MODE_SEPIA:
            color_out_in = pack(sep_r_q_ff, sep_g_q_ff, sep_b_q_ff);
         MODE_GRAY:
            color_out_in = pack(luma_q_ff, luma_q_ff, luma_q_ff);
         MODE_MONO:
            color_out_in = (luma_q_ff > 5'd15) ? pack(CH_MAX, CH_MAX, CH_MAX) : '0;
         MODE_INVERT:
            color_out_in = ~color_c_ff;
         MODE_SWAP:
            color_out_in = pack(b_c, g_c, r_c);
         default:
            color_out_in = color_c_ff;
      endcase
   end

   logic [WORD_W-1:0] color_d_ff;

   always_ff @(posedge clock) begin
      if (ready_d && valid_c_ff) begin
         color_d_ff <= color_out_in;
      end
   end

   assign rsp_valid     = valid_d_ff;
   assign rsp_color_out = color_d_ff;

`ifndef ASSERT_OFF
   // a stalled stage b keeps its beat
   a_stage_b_holds: assert property (@(posedge clock) disable iff (reset)
      valid_b_ff && !ready_c |=> valid_b_ff)
      else $error("stage b lost a beat while stalled");

   // the input side never stalls while the first stage is empty
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !valid_a_ff |-> req_ready)
      else $error("req_ready low with empty input stage");

   // the divide by 100 of the luma sum stays within one channel
   a_luma_in_range: assert property (@(posedge clock) disable iff (reset)
      valid_b_ff |-> luma_prod[PROD_W-1:RECIP_SHIFT+CH_W] == '0)
      else $error("luma quotient out of channel range");

   // gray output carries three equal channels and a clear top bit
   a_gray_equal: assert property (@(posedge clock) disable iff (reset)
      valid_c_ff && ready_d && mode_c_ff == MODE_GRAY |=>
         rsp_color_out[15] == 1'b0 && rsp_color_out[4:0] == rsp_color_out[9:5]
         && rsp_color_out[9:5] == rsp_color_out[14:10])
      else $error("gray output channels differ");
`endif

endmodule
